// File: rtl/wsd_pkg.sv
// shared constants and types for the work-stealing deque
`default_nettype none

package wsd_pkg;

    // job slots in the linear store
    localparam int DEPTH = 64;

    // index width holds 0..DEPTH, address width covers 0..DEPTH-1
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // fixed field widths
    localparam int OP_W  = 2;
    localparam int JOB_W = 32;
    localparam int OCC_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [JOB_W-1:0]  job_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // access to the job store
    typedef struct packed {
        logic  we;
        logic  re;
        addr_t addr;
        job_t  wdata;
    } store_cmd_t;

    // result fields waiting for the read data
    typedef struct packed {
        logic job_valid;
        logic push_accepted;
        occ_t occupancy;
    } rsp_meta_t;

endpackage

`default_nettype wire

// File: rtl/wsd_if.sv
// request and response channel interfaces of the deque
`default_nettype none

interface wsd_req_if;
    logic          valid;
    logic          ready;
    wsd_pkg::op_t  opcode;
    wsd_pkg::job_t job_handle;

    modport source (output valid, output opcode, output job_handle, input ready);
    modport sink   (input valid, input opcode, input job_handle, output ready);
endinterface

interface wsd_rsp_if;
    logic          valid;
    logic          ready;
    wsd_pkg::job_t job_out;
    logic          job_valid;
    logic          push_accepted;
    wsd_pkg::occ_t occupancy;

    modport source (output valid, output job_out, output job_valid,
                    output push_accepted, output occupancy, input ready);
    modport sink   (input valid, input job_out, input job_valid,
                    input push_accepted, input occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/wsd_store.sv
// job handle store: one write or one registered read per cycle
`default_nettype none

module wsd_store
(
    input  wire logic                clk,
    input  wire wsd_pkg::store_cmd_t cmd,
    output wsd_pkg::job_t            rd_data
);
    import wsd_pkg::*;

    job_t mem [DEPTH];
    job_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/work_stealing_deque.sv
// work-stealing deque top level: index control, job store and response register
//
//  channel | dir | fields                                        | request taken when
//  req     | in  | opcode, job_handle                            | req.valid && req.ready
//  rsp     | out | job_out, job_valid, push_accepted, occupancy  | rsp.valid && rsp.ready
//
// one request per cycle while req.ready is high; each response passes the pending stage
// indices update at acceptance, the store read is registered with them,
// then the response register loads; a write followed by a read of the
// same slot is safe because the write lands before the next read issues
// reset clears both indices and all valid flags; store contents are not cleared
// a stalled response holds the pending stage, which then holds req.ready low
`default_nettype none

module work_stealing_deque
(
    input  wire logic clk,
    input  wire logic rst_n,
    wsd_req_if.sink   req,
    wsd_rsp_if.source rsp
);
    import wsd_pkg::*;

    idx_t       top_reg, top_next;
    idx_t       bottom_reg, bottom_next;
    logic       pend_valid_reg, pend_valid_next;
    rsp_meta_t  pend_meta_reg, pend_meta_next;
    logic       out_valid_reg, out_valid_next;
    job_t       out_job_reg;
    rsp_meta_t  out_meta_reg;
    store_cmd_t cmd;
    job_t       rd_data;
    logic       fire;
    logic       pend_adv;
    idx_t       pop_slot;

    // handshake
    assign pend_adv  = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_valid_reg || !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign pop_slot  = bottom_reg - idx_t'(1);

    // operation decode and index update
    always_comb
    begin
        top_next    = top_reg;
        bottom_next = bottom_reg;
        cmd.we      = 1'b0;
        cmd.re      = 1'b0;
        cmd.addr    = bottom_reg[ADDR_W-1:0];
        cmd.wdata   = req.job_handle;
        pend_meta_next.job_valid     = 1'b0;
        pend_meta_next.push_accepted = 1'b0;
        if (fire)
        begin
            unique case (req.opcode)
                OP_PUSH:
                begin
                    if (bottom_reg < idx_t'(DEPTH))
                    begin
                        cmd.we      = 1'b1;
                        bottom_next = bottom_reg + idx_t'(1);
                        pend_meta_next.push_accepted = 1'b1;
                    end
                end
                OP_POP:
                begin
                    cmd.addr = pop_slot[ADDR_W-1:0];
                    if (bottom_reg > top_reg)
                    begin
                        cmd.re = 1'b1;
                        pend_meta_next.job_valid = 1'b1;
                        // last job: top moves past it to meet bottom
                        if (pop_slot == top_reg)
                        begin
                            top_next = bottom_reg;
                        end
                        else
                        begin
                            bottom_next = pop_slot;
                        end
                    end
                end
                OP_STEAL:
                begin
                    cmd.addr = top_reg[ADDR_W-1:0];
                    if (top_reg < bottom_reg)
                    begin
                        cmd.re   = 1'b1;
                        top_next = top_reg + idx_t'(1);
                        pend_meta_next.job_valid = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        pend_meta_next.occupancy = occ_t'(bottom_next - top_next);
    end

    // stage valid flags
    always_comb
    begin
        if (fire)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_adv)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end

        if (pend_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg        <= '0;
            bottom_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_meta_reg <= pend_meta_next;
        end
        if (pend_adv)
        begin
            out_meta_reg <= pend_meta_reg;
            out_job_reg  <= pend_meta_reg.job_valid ? rd_data : '0;
        end
    end

    // job store
    wsd_store u_store
    (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    // response channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.job_out       = out_job_reg;
    assign rsp.job_valid     = out_meta_reg.job_valid;
    assign rsp.push_accepted = out_meta_reg.push_accepted;
    assign rsp.occupancy     = out_meta_reg.occupancy;

endmodule

`default_nettype wire
